// ===== design/mrpa_pkg.sv =====
// Shared types, constants and defaults of the MQTT receive parser and acker.
package mrpa_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LEN_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int TYPE_W  = 4;
    localparam int QOS_W   = 2;
    localparam int IDENT_W = 16;
    localparam int LEN_W   = 28;
    localparam int LCNT_W  = 3;

    // Most length bytes whose seven bits are folded into the accumulator
    localparam int LEN_FIELDS = 4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TOPIC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    // Control packet types
    localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_PUBACK  = 4'd4;
    localparam logic [TYPE_W-1:0] TYPE_PUBREC  = 4'd5;
    localparam logic [TYPE_W-1:0] TYPE_PUBREL  = 4'd6;
    localparam logic [TYPE_W-1:0] TYPE_PUBCOMP = 4'd7;

    // QoS codes
    localparam logic [QOS_W-1:0] QOS_1 = 2'd1;
    localparam logic [QOS_W-1:0] QOS_2 = 2'd2;

    // Response fixed headers and their remaining length
    localparam logic [BYTE_W-1:0] RESP_PUBACK  = 8'h40;
    localparam logic [BYTE_W-1:0] RESP_PUBREC  = 8'h50;
    localparam logic [BYTE_W-1:0] RESP_PUBREL  = 8'h62;
    localparam logic [BYTE_W-1:0] RESP_PUBCOMP = 8'h70;
    localparam logic [BYTE_W-1:0] RESP_REMLEN  = 8'h02;

    // One request from the parser to the emitter: an optional data result,
    // an optional four-byte response and an optional done event.
    typedef struct packed {
        logic                has_data;
        logic [KIND_W-1:0]   data_kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [IDENT_W-1:0]  data_ident;
        logic                data_err;
        logic                has_resp;
        logic [BYTE_W-1:0]   resp_code;
        logic                has_done;
        logic [IDENT_W-1:0]  fin_ident;
        logic                fin_err;
        logic [TYPE_W-1:0]   ptype;
        logic [QOS_W-1:0]    qos;
        logic                retain;
        logic                dup;
        logic [LEN_W-1:0]    body_len;
    } t_cmd;

endpackage

// ===== design/mrpa_ifs.sv =====
// Channel interfaces: received byte stream and parser result stream.
interface mrpa_rx_if;
    logic                         valid;
    logic                         ready;
    logic [mrpa_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrpa_res_if;
    logic                          valid;
    logic                          ready;
    logic [mrpa_pkg::KIND_W-1:0]   out_kind;
    logic [mrpa_pkg::BYTE_W-1:0]   out_byte;
    logic                          out_last;
    logic [mrpa_pkg::TYPE_W-1:0]   packet_type;
    logic [mrpa_pkg::QOS_W-1:0]    qos_level;
    logic                          retain_flag;
    logic                          dup_flag;
    logic [mrpa_pkg::IDENT_W-1:0]  packet_ident;
    logic [mrpa_pkg::LEN_W-1:0]    body_length;
    logic                          malformed;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    output packet_type, output qos_level, output retain_flag,
                    output dup_flag, output packet_ident, output body_length,
                    output malformed, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    input packet_type, input qos_level, input retain_flag,
                    input dup_flag, input packet_ident, input body_length,
                    input malformed, output ready);
endinterface

// ===== design/mrpa_front.sv =====
// Parser front end: walks the packet byte by byte and issues emit requests.
module mrpa_front #(
    parameter int MAX_LEN_BYTES = mrpa_pkg::MAX_LEN_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mrpa_rx_if.sink        i_rx,
    input  logic           i_q_full,
    output logic           o_push,
    output mrpa_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        PH_HDR, PH_LEN, PH_DRAIN, PH_THI, PH_TLO, PH_TOPIC,
        PH_PHI, PH_PLO, PH_PAY, PH_IHI, PH_ILO, PH_SKIP
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [mrpa_pkg::BYTE_W-1:0]     r_hdr, n_hdr;
    logic [mrpa_pkg::LEN_W-1:0]      r_acc, n_acc;
    logic [mrpa_pkg::LCNT_W-1:0]     r_cnt, n_cnt;
    logic [mrpa_pkg::LEN_W-1:0]      r_left, n_left;
    logic [mrpa_pkg::IDENT_W-1:0]    r_topic, n_topic;
    logic [mrpa_pkg::IDENT_W-1:0]    r_ident, n_ident;
    logic                            r_err, n_err;

    logic                            accept;
    logic                            do_fin;
    logic [mrpa_pkg::BYTE_W-1:0]     b;
    logic [mrpa_pkg::LEN_W-1:0]      len_bits;
    logic [mrpa_pkg::LEN_W-1:0]      left_dec;
    logic [mrpa_pkg::TYPE_W-1:0]     ptype;
    logic                            is_pub;
    logic [mrpa_pkg::QOS_W-1:0]      qos;
    t_phase                          after_topic;
    mrpa_pkg::t_cmd                  cmd;

    assign b           = i_rx.rx_byte;
    assign i_rx.ready  = !i_q_full;
    assign accept      = i_rx.valid && !i_q_full;
    assign ptype       = r_hdr[7:4];
    assign is_pub      = (ptype == mrpa_pkg::TYPE_PUBLISH);
    assign qos         = is_pub ? r_hdr[2:1] : '0;
    assign after_topic = (qos != '0) ? PH_PHI : PH_PAY;
    assign left_dec    = (r_left != '0) ? r_left - 1'b1 : r_left;

    // Seven payload bits of a length byte placed at their weight
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    len_bits = {21'd0, b[6:0]};
            2'd1:    len_bits = {14'd0, b[6:0], 7'd0};
            2'd2:    len_bits = {7'd0, b[6:0], 14'd0};
            default: len_bits = {b[6:0], 21'd0};
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_topic = r_topic;
        n_ident = r_ident;
        n_err   = r_err;
        do_fin  = 1'b0;
        cmd     = '0;

        case (r_phase)
            PH_HDR: begin
                n_hdr   = b;
                n_acc   = '0;
                n_cnt   = '0;
                n_left  = '0;
                n_topic = '0;
                n_ident = '0;
                n_err   = 1'b0;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (r_cnt < mrpa_pkg::LCNT_W'(mrpa_pkg::LEN_FIELDS)) begin
                    n_acc = r_acc | len_bits;
                end
                n_cnt = r_cnt + 1'b1;
                if (b[7]) begin
                    if (n_cnt >= mrpa_pkg::LCNT_W'(MAX_LEN_BYTES)) begin
                        // Length field too long: flag and drop to its end
                        n_err         = 1'b1;
                        cmd.has_done  = 1'b1;
                        cmd.fin_err   = 1'b1;
                        cmd.fin_ident = r_ident;
                        n_phase       = PH_DRAIN;
                    end
                end else begin
                    n_left = n_acc;
                    if (is_pub) begin
                        n_phase = PH_THI;
                    end else if (ptype >= mrpa_pkg::TYPE_PUBACK &&
                                 ptype <= mrpa_pkg::TYPE_PUBCOMP) begin
                        n_phase = PH_IHI;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                    do_fin = (n_acc == '0);
                end
            end
            PH_DRAIN: begin
                if (!b[7]) begin
                    n_phase = PH_HDR;
                end
            end
            default: begin
                n_left = left_dec;
                case (r_phase)
                    PH_THI: begin
                        n_topic = {b, 8'd0};
                        n_phase = PH_TLO;
                    end
                    PH_TLO: begin
                        n_topic = {r_topic[15:8], b};
                        if ({12'd0, n_topic} > left_dec) begin
                            n_err = 1'b1;
                        end
                        n_phase = (n_topic != '0) ? PH_TOPIC : after_topic;
                    end
                    PH_TOPIC: begin
                        cmd.has_data  = 1'b1;
                        cmd.data_kind = mrpa_pkg::KIND_TOPIC;
                        cmd.data_byte = b;
                        n_topic       = r_topic - 1'b1;
                        if (n_topic == '0) begin
                            n_phase = after_topic;
                        end
                    end
                    PH_PHI: begin
                        n_ident = {b, 8'd0};
                        n_phase = PH_PLO;
                    end
                    PH_PLO: begin
                        n_ident = {r_ident[15:8], b};
                        n_phase = PH_PAY;
                    end
                    PH_PAY: begin
                        cmd.has_data  = 1'b1;
                        cmd.data_kind = mrpa_pkg::KIND_PAYLOAD;
                        cmd.data_byte = b;
                    end
                    PH_IHI: begin
                        n_ident = {b, 8'd0};
                        n_phase = PH_ILO;
                    end
                    PH_ILO: begin
                        n_ident = {r_ident[15:8], b};
                        n_phase = PH_SKIP;
                    end
                    default: begin
                    end
                endcase
                do_fin = (left_dec == '0);
            end
        endcase

        // Packet end: settle id and error, pick the response
        if (do_fin) begin
            if (is_pub) begin
                if (n_phase == PH_THI || n_phase == PH_TLO || n_phase == PH_TOPIC) begin
                    n_err = 1'b1;
                end
                if (n_phase != PH_PAY) begin
                    n_ident = '0;
                end
                if (!n_err && qos == mrpa_pkg::QOS_1) begin
                    cmd.has_resp  = 1'b1;
                    cmd.resp_code = mrpa_pkg::RESP_PUBACK;
                end else if (!n_err && qos == mrpa_pkg::QOS_2) begin
                    cmd.has_resp  = 1'b1;
                    cmd.resp_code = mrpa_pkg::RESP_PUBREC;
                end
            end else if (ptype >= mrpa_pkg::TYPE_PUBACK && ptype <= mrpa_pkg::TYPE_PUBCOMP) begin
                if (n_phase != PH_SKIP) begin
                    n_ident = '0;
                end
                if (ptype == mrpa_pkg::TYPE_PUBREC) begin
                    cmd.has_resp  = 1'b1;
                    cmd.resp_code = mrpa_pkg::RESP_PUBREL;
                end else if (ptype == mrpa_pkg::TYPE_PUBREL) begin
                    cmd.has_resp  = 1'b1;
                    cmd.resp_code = mrpa_pkg::RESP_PUBCOMP;
                end
            end
            cmd.has_done  = 1'b1;
            cmd.fin_ident = n_ident;
            cmd.fin_err   = n_err;
            n_phase       = PH_HDR;
        end

        cmd.data_ident = r_ident;
        cmd.data_err   = r_err;
        cmd.ptype      = ptype;
        cmd.qos        = qos;
        cmd.retain     = is_pub & r_hdr[0];
        cmd.dup        = is_pub & r_hdr[3];
        cmd.body_len   = n_acc;
    end

    assign o_push = accept && (cmd.has_data || cmd.has_done);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_hdr   <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_topic <= '0;
            r_ident <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_topic <= n_topic;
            r_ident <= n_ident;
            r_err   <= n_err;
        end
    end

endmodule

// ===== design/mrpa_queue.sv =====
// Request queue between the parser and the emitter.
module mrpa_queue #(
    parameter int QUEUE_DEPTH = mrpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrpa_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mrpa_pkg::t_cmd o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    mrpa_pkg::t_cmd  r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/mrpa_back.sv =====
// Emitter back end: expands each request into its result items.
module mrpa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mrpa_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    mrpa_res_if.source     o_res
);

    typedef enum logic [2:0] {
        SL_DATA, SL_RESP0, SL_RESP1, SL_RESP2, SL_RESP3, SL_DONE
    } t_slot;

    logic            r_busy;
    t_slot           r_slot, n_slot, first_slot;
    mrpa_pkg::t_cmd  r_cmd;
    logic            last;
    logic            take;
    logic            load;
    logic            use_fin;

    assign take = r_busy && o_res.ready;
    assign load = !r_busy || (take && last);
    assign o_q_pop = load && i_q_valid;

    always_comb begin
        if (i_q_data.has_data) begin
            first_slot = SL_DATA;
        end else if (i_q_data.has_resp) begin
            first_slot = SL_RESP0;
        end else begin
            first_slot = SL_DONE;
        end
    end

    // Following slot of the current request, or its end
    always_comb begin
        n_slot = SL_DONE;
        last   = 1'b1;
        case (r_slot)
            SL_DATA: begin
                if (r_cmd.has_resp) begin
                    n_slot = SL_RESP0;
                    last   = 1'b0;
                end else if (r_cmd.has_done) begin
                    last   = 1'b0;
                end
            end
            SL_RESP0: begin
                n_slot = SL_RESP1;
                last   = 1'b0;
            end
            SL_RESP1: begin
                n_slot = SL_RESP2;
                last   = 1'b0;
            end
            SL_RESP2: begin
                n_slot = SL_RESP3;
                last   = 1'b0;
            end
            SL_RESP3: begin
                last = !r_cmd.has_done;
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SL_DONE;
        end else if (load) begin
            r_busy <= i_q_valid;
            r_slot <= first_slot;
        end else if (take) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_cmd <= i_q_data;
        end
    end

    assign use_fin = (r_slot != SL_DATA);

    always_comb begin
        case (r_slot)
            SL_DATA: begin
                o_res.out_kind = r_cmd.data_kind;
                o_res.out_byte = r_cmd.data_byte;
            end
            SL_RESP0: begin
                o_res.out_kind = mrpa_pkg::KIND_RESP;
                o_res.out_byte = r_cmd.resp_code;
            end
            SL_RESP1: begin
                o_res.out_kind = mrpa_pkg::KIND_RESP;
                o_res.out_byte = mrpa_pkg::RESP_REMLEN;
            end
            SL_RESP2: begin
                o_res.out_kind = mrpa_pkg::KIND_RESP;
                o_res.out_byte = r_cmd.fin_ident[15:8];
            end
            SL_RESP3: begin
                o_res.out_kind = mrpa_pkg::KIND_RESP;
                o_res.out_byte = r_cmd.fin_ident[7:0];
            end
            default: begin
                o_res.out_kind = mrpa_pkg::KIND_DONE;
                o_res.out_byte = '0;
            end
        endcase
    end

    assign o_res.valid        = r_busy;
    assign o_res.out_last     = last;
    assign o_res.packet_type  = r_cmd.ptype;
    assign o_res.qos_level    = r_cmd.qos;
    assign o_res.retain_flag  = r_cmd.retain;
    assign o_res.dup_flag     = r_cmd.dup;
    assign o_res.packet_ident = use_fin ? r_cmd.fin_ident : r_cmd.data_ident;
    assign o_res.body_length  = r_cmd.body_len;
    assign o_res.malformed    = use_fin ? r_cmd.fin_err : r_cmd.data_err;

endmodule

// ===== design/mqtt_receive_parser_acker_top.sv =====
// MQTT 3.1.1 receive parser and acknowledger, top level.
//
// i_rx carries the bytes received from the broker, one per request.
// o_res carries the results: topic bytes, payload bytes, the four bytes of
// any PUBACK, PUBREC, PUBREL or PUBCOMP reply that is due, and a done event
// at the end of each packet or on an over-long length field. out_last marks
// the final result caused by one received byte.
//
// The parser front end takes one byte per cycle while the queue is not full
// and turns it into at most one request; the emitter back end spells that
// request out at one result per cycle while o_res is ready (up to six for a
// byte that ends a packet). A queue of QUEUE_DEPTH requests lies between
// them; a byte's request is written into the queue, then loaded into the
// emitter, and bytes that cause at most one result stream at one per cycle.
// Throughput is bounded by the emitter; the queue soaks up reply bursts.
//
// i_rx.ready falls only when the queue is full, which happens when the
// emitter falls behind, as when o_res stalls; results are held stable until
// taken. Synchronous reset empties the queue, drops any partial result
// burst and waits for a fresh fixed header.
module mqtt_receive_parser_acker_top #(
    parameter int MAX_LEN_BYTES = mrpa_pkg::MAX_LEN_BYTES_DEF,
    parameter int QUEUE_DEPTH   = mrpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrpa_rx_if.sink     i_rx,
    mrpa_res_if.source  o_res
);

    logic            push, q_full, q_valid, q_pop;
    mrpa_pkg::t_cmd  push_cmd, q_cmd;

    // Parse: one byte in, at most one request out
    mrpa_front #(
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Hold requests while the emitter is busy
    mrpa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Expand each request into its results
    mrpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== design/mrpa_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module mrpa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mrpa_pkg::KIND_W-1:0]   i_out_kind,
    input  logic [mrpa_pkg::BYTE_W-1:0]   i_out_byte,
    input  logic                          i_out_last
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)
                                           && $stable(i_out_kind)))
        else $error("stalled result changed");

    // Reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // A done event carries a zero byte and closes its burst
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == mrpa_pkg::KIND_DONE) |->
            (i_out_byte == '0 && i_out_last))
        else $error("malformed done event");

    // A reply byte is always followed by more of the burst
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == mrpa_pkg::KIND_RESP) |-> !i_out_last)
        else $error("reply byte marked last");

endmodule

bind mqtt_receive_parser_acker_top mrpa_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.out_kind),
    .i_out_byte  (o_res.out_byte),
    .i_out_last  (o_res.out_last)
);
